// ===== rtl/core/rxfx_pkg.sv =====
package rxfx_pkg;

  // buffer geometry and register reset values
  localparam int unsigned DEPTH_DEFAULT = 256;
  localparam int unsigned THRESH_W      = 9;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned FILL_W        = 9;

  localparam logic [THRESH_W-1:0] XOFF_THRESH_RESET = 9'd64;
  localparam logic [THRESH_W-1:0] XON_THRESH_RESET  = 9'd8;

  // flow control characters
  localparam logic [BYTE_W-1:0] CHAR_XON  = 8'h11;
  localparam logic [BYTE_W-1:0] CHAR_XOFF = 8'h13;
  localparam logic [BYTE_W-1:0] CHAR_NONE = 8'h00;

  // operation codes
  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // configuration register indexes
  localparam logic CFG_XOFF_THRESH = 1'b0;
  localparam logic CFG_XON_THRESH  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic take_store;  // store beat accepted
    logic take_read;   // read beat accepted, buffer not empty
    logic take_empty;  // read beat accepted, buffer empty
    logic land_read;   // ram read data available
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
  } dp_status_t;

endpackage

// ===== rtl/core/rxfx_ram.sv =====
module rxfx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/rxfx_ctrl.sv =====
module rxfx_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   func,
  input  logic                   out_ready,
  input  rxfx_pkg::dp_status_t   status,
  output logic                   in_ready,
  output logic                   out_valid,
  output rxfx_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_HOLD
  } state_t;

  state_t state;
  logic   accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    cmd            = '0;
    cmd.take_store = accept && (func == rxfx_pkg::FUNC_STORE);
    cmd.take_read  = accept && (func == rxfx_pkg::FUNC_READ) && !status.empty;
    cmd.take_empty = accept && (func == rxfx_pkg::FUNC_READ) && status.empty;
    cmd.land_read  = (state == ST_RD_WAIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.take_read) begin
            state    <= ST_RD_WAIT;
            in_ready <= 1'b0;
          end else if (accept) begin
            state     <= ST_HOLD;
            in_ready  <= 1'b0;
            out_valid <= 1'b1;
          end
        end
        ST_RD_WAIT: begin
          state     <= ST_HOLD;
          out_valid <= 1'b1;
        end
        ST_HOLD: begin
          if (out_ready) begin
            state     <= ST_IDLE;
            in_ready  <= 1'b1;
            out_valid <= 1'b0;
          end
        end
        default: begin
          state     <= ST_IDLE;
          in_ready  <= 1'b1;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/rxfx_dpath.sv =====
module rxfx_dpath #(
  parameter int unsigned DEPTH = rxfx_pkg::DEPTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  rxfx_pkg::ctrl_cmd_t                  cmd,
  output rxfx_pkg::dp_status_t                 status,
  input  logic [rxfx_pkg::BYTE_W-1:0]          rx_byte,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [rxfx_pkg::THRESH_W-1:0]        cfg_data,
  output logic                                 read_valid,
  output logic [rxfx_pkg::BYTE_W-1:0]          read_data,
  output logic                                 flow_send,
  output logic [rxfx_pkg::BYTE_W-1:0]          flow_char,
  output logic                                 overflow,
  output logic [rxfx_pkg::FILL_W-1:0]          fill_level
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned OCC_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (OCC_W > rxfx_pkg::THRESH_W) ? OCC_W : rxfx_pkg::THRESH_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

  logic [PTR_W-1:0]              wr_ptr;
  logic [PTR_W-1:0]              rd_ptr;
  logic [OCC_W-1:0]              occ;
  logic [rxfx_pkg::THRESH_W-1:0] xoff_thresh;
  logic [rxfx_pkg::THRESH_W-1:0] xon_thresh;
  logic [rxfx_pkg::BYTE_W-1:0]   ram_q;

  logic             full;
  logic             do_write;
  logic [OCC_W-1:0] occ_inc;
  logic [OCC_W-1:0] occ_dec;
  logic [OCC_W-1:0] occ_after_store;
  logic [CMP_W-1:0] store_lvl;
  logic [CMP_W-1:0] read_lvl;
  logic [CMP_W-1:0] empty_lvl;

  assign full            = (occ == OCC_FULL);
  assign status.empty    = (occ == '0);
  assign do_write        = cmd.take_store && !full;
  assign occ_inc         = occ + OCC_W'(1);
  assign occ_dec         = occ - OCC_W'(1);
  assign occ_after_store = full ? occ : occ_inc;
  assign store_lvl       = CMP_W'(occ_after_store);
  assign read_lvl        = CMP_W'(occ_dec);
  assign empty_lvl       = CMP_W'(occ);

  rxfx_ram #(
    .WIDTH (rxfx_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (do_write),
    .waddr (wr_ptr),
    .wdata (rx_byte),
    .re    (cmd.take_read),
    .raddr (rd_ptr),
    .rdata (ram_q)
  );

  // pointers, occupancy and threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      occ         <= '0;
      xoff_thresh <= rxfx_pkg::XOFF_THRESH_RESET;
      xon_thresh  <= rxfx_pkg::XON_THRESH_RESET;
    end else begin
      if (do_write) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
        occ    <= occ_inc;
      end
      if (cmd.take_read) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
        occ    <= occ_dec;
      end
      if (cfg_we) begin
        if (cfg_index == rxfx_pkg::CFG_XOFF_THRESH) begin
          xoff_thresh <= cfg_data;
        end else begin
          xon_thresh <= cfg_data;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.take_store) begin
      read_valid <= 1'b0;
      read_data  <= '0;
      overflow   <= full;
      fill_level <= store_lvl[rxfx_pkg::FILL_W-1:0];
      flow_send  <= (store_lvl > CMP_W'(xoff_thresh));
      flow_char  <= (store_lvl > CMP_W'(xoff_thresh)) ? rxfx_pkg::CHAR_XOFF
                                                       : rxfx_pkg::CHAR_NONE;
    end
    if (cmd.take_read) begin
      read_valid <= 1'b1;
      read_data  <= '0;
      overflow   <= 1'b0;
      fill_level <= read_lvl[rxfx_pkg::FILL_W-1:0];
      flow_send  <= (read_lvl < CMP_W'(xon_thresh));
      flow_char  <= (read_lvl < CMP_W'(xon_thresh)) ? rxfx_pkg::CHAR_XON
                                                    : rxfx_pkg::CHAR_NONE;
    end
    if (cmd.take_empty) begin
      read_valid <= 1'b0;
      read_data  <= '0;
      overflow   <= 1'b0;
      fill_level <= empty_lvl[rxfx_pkg::FILL_W-1:0];
      flow_send  <= 1'b0;
      flow_char  <= rxfx_pkg::CHAR_NONE;
    end
    if (cmd.land_read) begin
      read_data <= ram_q;
    end
  end

endmodule

// ===== rtl/core/rx_fifo_xon_xoff_top.sv =====
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   func, rx_byte
// out       output     out_valid / out_ready read_valid, read_data, flow_send, flow_char,
//                                            overflow, fill_level
// cfg       input      cfg_we (no wait)      cfg_index, cfg_data
//
// one beat at a time: a store or a read of an empty buffer has its result valid
// the cycle after accept; a read that returns a byte first passes a ram wait
// state (registered ram read port) before its result is valid
// in_ready comes back in the cycle after the result beat is taken
// rst is synchronous: pointers and fill count clear, thresholds load 64 and 8
// ram contents are not cleared; only written entries are ever read
// out_ready low holds the result and keeps in_ready low
module rx_fifo_xon_xoff_top #(
  parameter int unsigned DEPTH = rxfx_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // input item channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic [rxfx_pkg::BYTE_W-1:0]   rx_byte,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          read_valid,
  output logic [rxfx_pkg::BYTE_W-1:0]   read_data,
  output logic                          flow_send,
  output logic [rxfx_pkg::BYTE_W-1:0]   flow_char,
  output logic                          overflow,
  output logic [rxfx_pkg::FILL_W-1:0]   fill_level,
  // threshold register writes
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rxfx_pkg::THRESH_W-1:0] cfg_data
);

  rxfx_pkg::ctrl_cmd_t  cmd;
  rxfx_pkg::dp_status_t status;

  // sequencer: accept, optional ram wait, hold result until taken
  rxfx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .func      (func),
    .out_ready (out_ready),
    .status    (status),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // ring buffer, pointers, fill count, thresholds and result register
  rxfx_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .rx_byte    (rx_byte),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .read_valid (read_valid),
    .read_data  (read_data),
    .flow_send  (flow_send),
    .flow_char  (flow_char),
    .overflow   (overflow),
    .fill_level (fill_level)
  );

`ifndef SYNTHESIS
  // a dropped byte never comes with read data
  a_ovf_not_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> !read_valid)
    else $error("overflow flagged on a read result");

  // a read result only ever asks for xon
  a_read_xon: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_valid && flow_send |-> flow_char == rxfx_pkg::CHAR_XON)
    else $error("read result requested a character other than xon");

  // an overflow always means a full buffer, and a full store asks xoff or nothing
  a_ovf_xoff: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow && flow_send |-> flow_char == rxfx_pkg::CHAR_XOFF)
    else $error("overflow result requested a character other than xoff");

  // no second beat accepted while one is in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready while a beat is in flight");
`endif

endmodule
